FILE: rtl/core/rc4_keystream_xor_unit_assert.svh
// assertion macros for the rc4 keystream unit
// depends on nothing; expects clock and reset in the including scope
`ifndef RC4_KEYSTREAM_XOR_UNIT_ASSERT_SVH
`define RC4_KEYSTREAM_XOR_UNIT_ASSERT_SVH

// same-cycle implication
`define RC4_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("rc4 assertion failed");

// next-cycle implication
`define RC4_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("rc4 assertion failed");

`endif

FILE: rtl/core/rc4_pkg.sv
// package for the rc4 keystream unit: microcode word, step codes, program rom
// depends on nothing
package rc4_pkg;

   localparam int KEY_LEN   = 8;
   localparam int KEY_IDX_W = (KEY_LEN > 1) ? $clog2(KEY_LEN) : 1;
   localparam int STEP_W    = 4;

   typedef logic [STEP_W-1:0] step_type;

   localparam step_type ST_WAIT = 4'd0;
   localparam step_type ST_KS0  = 4'd1;
   localparam step_type ST_KI   = 4'd2;
   localparam step_type ST_KA   = 4'd3;
   localparam step_type ST_KB   = 4'd4;
   localparam step_type ST_KC   = 4'd5;
   localparam step_type ST_KD   = 4'd6;
   localparam step_type ST_KE   = 4'd7;
   localparam step_type ST_P1   = 4'd8;
   localparam step_type ST_P2   = 4'd9;
   localparam step_type ST_P3   = 4'd10;

   typedef enum logic [2:0] {
      A_I_INC, A_I, A_J_SUM, A_J_KEY_SUM, A_T_SUM, A_T
   } addr_sel_type;

   typedef enum logic [1:0] {
      W_NONE, W_I_IDENT, W_I_RD, W_J_SI
   } wr_sel_type;

   typedef enum logic [1:0] {
      I_HOLD, I_CLR, I_INC
   } i_op_type;

   typedef enum logic [1:0] {
      J_HOLD, J_CLR, J_ADD_RD, J_ADD_RD_KEY
   } j_op_type;

   typedef enum logic [2:0] {
      BR_NEXT, BR_JUMP, BR_WAIT, BR_LOOP_I, BR_OUT
   } br_type;

   typedef struct packed {
      addr_sel_type addr_sel;
      wr_sel_type   wr_sel;
      i_op_type     i_op;
      j_op_type     j_op;
      logic         ld_si;
      logic         ld_sj;
      logic         ld_out;
      br_type       br;
      step_type     target;
   } ctrl_word_type;

   function automatic ctrl_word_type ucode_rom(input step_type step);
      ctrl_word_type cw;
      cw = '{addr_sel: A_I_INC, wr_sel: W_NONE, i_op: I_HOLD, j_op: J_HOLD,
             ld_si: 1'b0, ld_sj: 1'b0, ld_out: 1'b0, br: BR_JUMP, target: ST_WAIT};
      case (step)
         ST_WAIT: begin
            cw.br     = BR_WAIT;
            cw.target = ST_P1;
         end
         ST_KS0: begin
            cw.i_op = I_CLR;
            cw.j_op = J_CLR;
            cw.br   = BR_NEXT;
         end
         ST_KI: begin
            cw.wr_sel = W_I_IDENT;
            cw.i_op   = I_INC;
            cw.br     = BR_LOOP_I;
            cw.target = ST_KI;
         end
         ST_KA: begin
            cw.addr_sel = A_I;
            cw.br       = BR_NEXT;
         end
         ST_KB: begin
            cw.addr_sel = A_J_KEY_SUM;
            cw.j_op     = J_ADD_RD_KEY;
            cw.ld_si    = 1'b1;
            cw.br       = BR_NEXT;
         end
         ST_KC: begin
            cw.wr_sel = W_I_RD;
            cw.ld_sj  = 1'b1;
            cw.br     = BR_NEXT;
         end
         ST_KD: begin
            cw.wr_sel = W_J_SI;
            cw.i_op   = I_INC;
            cw.br     = BR_LOOP_I;
            cw.target = ST_KA;
         end
         ST_KE: begin
            cw.j_op = J_CLR;
            cw.br   = BR_NEXT;
         end
         ST_P1: begin
            cw.addr_sel = A_J_SUM;
            cw.i_op     = I_INC;
            cw.j_op     = J_ADD_RD;
            cw.ld_si    = 1'b1;
            cw.br       = BR_NEXT;
         end
         ST_P2: begin
            cw.addr_sel = A_T_SUM;
            cw.wr_sel   = W_I_RD;
            cw.ld_sj    = 1'b1;
            cw.br       = BR_NEXT;
         end
         ST_P3: begin
            cw.addr_sel = A_T;
            cw.wr_sel   = W_J_SI;
            cw.ld_out   = 1'b1;
            cw.br       = BR_OUT;
            cw.target   = ST_WAIT;
         end
         default: begin
            cw.br     = BR_JUMP;
            cw.target = ST_WAIT;
         end
      endcase
      return cw;
   endfunction

endpackage

FILE: rtl/core/rc4_keystream_xor_unit.sv
// rc4 keystream xor unit: each byte passes the wait step plus three program steps,
// result registered in step P3 after P1 and P2; P3 holds while rsp is stalled, and no new byte is taken before WAIT
// restart adds a key schedule: 256 identity fills, 256 rounds of 4 steps
// throughput is set by the one-read one-write 256-entry state memory and its registered read
// synchronous active-high reset clears the step counter, indices, key and result valid
// state memory content is undefined until the first restart
module rc4_keystream_xor_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [63:0] csr_key_bytes,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_in,
   input  logic        req_restart,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_data_out
);
   import rc4_pkg::*;

   logic [7:0] perm_mem [256];

   step_type                  step_ff, step_in;
   logic [KEY_LEN-1:0][7:0]   key_ff;
   logic [KEY_IDX_W-1:0]      kidx_ff, kidx_in;
   logic [7:0]                i_ff, i_in;
   logic [7:0]                j_ff, j_in;
   logic [7:0]                si_ff, sj_ff, t_ff;
   logic [7:0]                rd_ff;
   logic [7:0]                data_ff, out_data_ff;
   logic                      restart_ff, out_valid_ff;

   ctrl_word_type cw;
   logic [7:0]    rd_addr, wr_addr, wr_data, key_byte, j_key_sum, ks;
   logic          wr_en, accept, out_free;

   assign cw        = ucode_rom(step_ff);
   assign req_ready = (step_ff == ST_WAIT);
   assign accept    = req_valid && req_ready;
   assign out_free  = !out_valid_ff || rsp_ready;
   assign key_byte  = key_ff[kidx_ff];
   assign j_key_sum = j_ff + rd_ff + key_byte;
   assign rsp_valid    = out_valid_ff;
   assign rsp_data_out = out_data_ff;

   // keystream byte after the swap, bypassing the two fresh writes
   always_comb begin
      if (t_ff == i_ff) begin
         ks = sj_ff;
      end else if (t_ff == j_ff) begin
         ks = si_ff;
      end else begin
         ks = rd_ff;
      end
   end

   always_comb begin
      case (cw.addr_sel)
         A_I_INC:     rd_addr = i_ff + 8'd1;
         A_I:         rd_addr = i_ff;
         A_J_SUM:     rd_addr = j_ff + rd_ff;
         A_J_KEY_SUM: rd_addr = j_key_sum;
         A_T_SUM:     rd_addr = si_ff + rd_ff;
         A_T:         rd_addr = t_ff;
         default:     rd_addr = i_ff;
      endcase
   end

   always_comb begin
      wr_en   = 1'b1;
      wr_addr = i_ff;
      wr_data = rd_ff;
      case (cw.wr_sel)
         W_NONE:    wr_en = 1'b0;
         W_I_IDENT: wr_data = i_ff;
         W_I_RD:    wr_data = rd_ff;
         W_J_SI: begin
            wr_addr = j_ff;
            wr_data = si_ff;
         end
         default:   wr_en = 1'b0;
      endcase
   end

   always_comb begin
      case (cw.i_op)
         I_CLR:   i_in = 8'd0;
         I_INC:   i_in = i_ff + 8'd1;
         default: i_in = i_ff;
      endcase
      case (cw.j_op)
         J_CLR:        j_in = 8'd0;
         J_ADD_RD:     j_in = j_ff + rd_ff;
         J_ADD_RD_KEY: j_in = j_key_sum;
         default:      j_in = j_ff;
      endcase
   end

   // key byte position, advancing once per schedule round and wrapping at the key length
   always_comb begin
      kidx_in = kidx_ff;
      if (cw.i_op == I_CLR) begin
         kidx_in = '0;
      end else if ((cw.wr_sel == W_J_SI) && (cw.i_op == I_INC)) begin
         kidx_in = (kidx_ff == KEY_IDX_W'(KEY_LEN - 1)) ? '0 : kidx_ff + 1'b1;
      end
   end

   // sequencer branch logic
   always_comb begin
      case (cw.br)
         BR_NEXT: step_in = step_ff + 4'd1;
         BR_JUMP: step_in = cw.target;
         BR_WAIT: begin
            if (!accept) begin
               step_in = step_ff;
            end else if (req_restart) begin
               step_in = step_ff + 4'd1;
            end else begin
               step_in = cw.target;
            end
         end
         BR_LOOP_I: step_in = (i_ff != 8'hFF) ? cw.target : step_ff + 4'd1;
         BR_OUT:    step_in = out_free ? cw.target : step_ff;
         default:   step_in = ST_WAIT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         perm_mem[wr_addr] <= wr_data;
      end
      rd_ff <= perm_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= ST_WAIT;
         i_ff         <= 8'd0;
         j_ff         <= 8'd0;
         kidx_ff      <= '0;
         key_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         i_ff    <= i_in;
         j_ff    <= j_in;
         kidx_ff <= kidx_in;
         if (csr_write_enable) begin
            key_ff <= csr_key_bytes[8*KEY_LEN-1:0];
         end
         if (cw.ld_out && out_free) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         data_ff    <= req_data_in;
         restart_ff <= req_restart;
      end
      if (cw.ld_si) begin
         si_ff <= rd_ff;
      end
      if (cw.ld_sj) begin
         sj_ff <= rd_ff;
         t_ff  <= si_ff + rd_ff;
      end
      if (cw.ld_out && out_free) begin
         out_data_ff <= data_ff ^ ks;
      end
   end

`include "rc4_keystream_xor_unit_assert.svh"

   `RC4_ASSERT_NEXT(a_stall_holds, (step_ff == ST_P3) && !out_free, step_ff == ST_P3)
   `RC4_ASSERT_NEXT(a_sched_end, (step_ff == ST_KD) && (i_ff == 8'hFF), (i_ff == 8'd0) && (step_ff == ST_KE))
   `RC4_ASSERT_NEXT(a_plain_accept, accept && !req_restart, (step_ff == ST_P1) && !restart_ff)
   `RC4_ASSERT_NOW(a_ready_only_wait, req_ready, !cw.ld_out && (cw.wr_sel == W_NONE))

endmodule
